FILE: sv/smm_pkg.sv
// Shared constants, command/status types and helpers for the small matrix multiplier.
package smm_pkg;

    // Matrix geometry
    localparam int MAX_SIZE     = 4;
    localparam int ELEMENT_BITS = 16;
    localparam int IDX_BITS     = $clog2(MAX_SIZE);
    localparam int SIZE_BITS    = $clog2(MAX_SIZE + 1);
    localparam int STORE_DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
    localparam int CFG_BITS     = 3;

    // Arithmetic and result fields
    localparam int PROD_BITS    = 2 * ELEMENT_BITS;
    localparam int SUM_BITS     = 34;
    localparam int ROW_BITS     = 2;
    localparam int COL_BITS     = 2;

    // Stream widths, padded to whole bytes
    localparam int S_DATA_BITS  = ((ELEMENT_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = SUM_BITS + ROW_BITS + COL_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;
    localparam int M_PAD_BITS   = M_DATA_BITS - M_FIELD_BITS;

    // Result queue
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                 wr_en;
        logic                 wr_right;
        logic [ADDR_BITS-1:0] wr_addr;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_left_addr;
        logic [ADDR_BITS-1:0] rd_right_addr;
        logic                 first;
        logic                 last;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        logic                 final_elem;
    } cmd_t;

    // Tag that travels with one term through the MAC pipeline
    typedef struct packed {
        logic                first;
        logic                last;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                final_elem;
    } tag_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_pop;
    } stat_t;

    // Clamp the configured size into the supported range
    function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [CFG_BITS-1:0] v);
        logic [SIZE_BITS-1:0] n;
        if (int'(v) < 2)
        begin
            n = SIZE_BITS'(2);
        end
        else if (int'(v) > MAX_SIZE)
        begin
            n = SIZE_BITS'(MAX_SIZE);
        end
        else
        begin
            n = SIZE_BITS'(v);
        end
        return n;
    endfunction

    // Store address of element (row, col)
    function automatic logic [ADDR_BITS-1:0] elem_addr(input logic [IDX_BITS-1:0] row,
                                                       input logic [IDX_BITS-1:0] col);
        return ADDR_BITS'(int'(row) * MAX_SIZE + int'(col));
    endfunction

endpackage

FILE: sv/smm_ctrl.sv
// Controller: load sequencing, product element scheduling and result credit tracking.
module smm_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [smm_pkg::CFG_BITS-1:0] cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  smm_pkg::stat_t               stat,
    output smm_pkg::cmd_t                cmd
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_CALC = 1'b1;

    logic                             state_reg,    state_next;
    logic [smm_pkg::CFG_BITS-1:0]     size_reg,     size_next;
    logic [smm_pkg::IDX_BITS-1:0]     ld_row_reg,   ld_row_next;
    logic [smm_pkg::IDX_BITS-1:0]     ld_col_reg,   ld_col_next;
    logic                             ld_right_reg, ld_right_next;
    logic [smm_pkg::IDX_BITS-1:0]     cr_reg,       cr_next;
    logic [smm_pkg::IDX_BITS-1:0]     cc_reg,       cc_next;
    logic [smm_pkg::IDX_BITS-1:0]     ck_reg,       ck_next;
    logic [smm_pkg::OUT_CNT_BITS-1:0] credit_reg,   credit_next;

    logic [smm_pkg::SIZE_BITS-1:0]    n;
    logic [smm_pkg::IDX_BITS-1:0]     last_idx;
    logic                             accept;
    logic                             start_ok;
    logic                             issue;
    logic                             start;

    // Effective size and handshake decode
    always_comb
    begin
        n        = smm_pkg::clamp_size(size_reg);
        last_idx = smm_pkg::IDX_BITS'(n - smm_pkg::SIZE_BITS'(1));
        accept   = s_tvalid && (state_reg == ST_LOAD);
        start_ok = credit_reg < smm_pkg::OUT_CNT_BITS'(smm_pkg::OUT_DEPTH);
        issue    = (state_reg == ST_CALC) && ((ck_reg != '0) || start_ok);
        start    = issue && (ck_reg == '0);
    end

    assign s_tready = (state_reg == ST_LOAD);

    // Sequence loads and product terms
    always_comb
    begin
        state_next    = state_reg;
        size_next     = size_reg;
        ld_row_next   = ld_row_reg;
        ld_col_next   = ld_col_reg;
        ld_right_next = ld_right_reg;
        cr_next       = cr_reg;
        cc_next       = cc_reg;
        ck_next       = ck_reg;

        if (cfg_we)
        begin
            // Drop any partial load
            size_next     = cfg_wdata;
            ld_row_next   = '0;
            ld_col_next   = '0;
            ld_right_next = 1'b0;
            state_next    = ST_LOAD;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (ld_col_reg == last_idx)
                        begin
                            ld_col_next = '0;
                            if (ld_row_reg == last_idx)
                            begin
                                ld_row_next = '0;
                                if (ld_right_reg)
                                begin
                                    ld_right_next = 1'b0;
                                    cr_next       = '0;
                                    cc_next       = '0;
                                    ck_next       = '0;
                                    state_next    = ST_CALC;
                                end
                                else
                                begin
                                    ld_right_next = 1'b1;
                                end
                            end
                            else
                            begin
                                ld_row_next = ld_row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ld_col_next = ld_col_reg + 1'b1;
                        end
                    end
                end
                ST_CALC:
                begin
                    if (issue)
                    begin
                        if (ck_reg == last_idx)
                        begin
                            ck_next = '0;
                            if (cc_reg == last_idx)
                            begin
                                cc_next = '0;
                                if (cr_reg == last_idx)
                                begin
                                    cr_next    = '0;
                                    state_next = ST_LOAD;
                                end
                                else
                                begin
                                    cr_next = cr_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                cc_next = cc_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ck_next = ck_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_LOAD;
                end
            endcase
        end
    end

    // Count product elements started but not yet taken downstream
    always_comb
    begin
        credit_next = credit_reg;
        if (start && !stat.out_pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!start && stat.out_pop)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    // Drive datapath commands
    always_comb
    begin
        cmd.wr_en         = accept;
        cmd.wr_right      = ld_right_reg;
        cmd.wr_addr       = smm_pkg::elem_addr(ld_row_reg, ld_col_reg);
        cmd.rd_en         = issue;
        cmd.rd_left_addr  = smm_pkg::elem_addr(cr_reg, ck_reg);
        cmd.rd_right_addr = smm_pkg::elem_addr(ck_reg, cc_reg);
        cmd.first         = (ck_reg == '0);
        cmd.last          = (ck_reg == last_idx);
        cmd.row           = smm_pkg::ROW_BITS'(cr_reg);
        cmd.col           = smm_pkg::COL_BITS'(cc_reg);
        cmd.final_elem    = (cr_reg == last_idx) && (cc_reg == last_idx);
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            size_reg     <= smm_pkg::CFG_BITS'(4);
            ld_row_reg   <= '0;
            ld_col_reg   <= '0;
            ld_right_reg <= 1'b0;
            cr_reg       <= '0;
            cc_reg       <= '0;
            ck_reg       <= '0;
            credit_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            size_reg     <= size_next;
            ld_row_reg   <= ld_row_next;
            ld_col_reg   <= ld_col_next;
            ld_right_reg <= ld_right_next;
            cr_reg       <= cr_next;
            cc_reg       <= cc_next;
            ck_reg       <= ck_next;
            credit_reg   <= credit_next;
        end
    end

endmodule

FILE: sv/smm_datapath.sv
// Datapath: element stores, multiply-accumulate pipeline and result queue.
module smm_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  smm_pkg::cmd_t                   cmd,
    input  logic [smm_pkg::S_DATA_BITS-1:0] s_tdata,
    output smm_pkg::stat_t                  stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [smm_pkg::M_DATA_BITS-1:0] m_tdata,
    output logic                            m_tlast
);

    logic [smm_pkg::ELEMENT_BITS-1:0] left_mem  [smm_pkg::STORE_DEPTH];
    logic [smm_pkg::ELEMENT_BITS-1:0] right_mem [smm_pkg::STORE_DEPTH];

    logic signed [smm_pkg::ELEMENT_BITS-1:0] a_reg;
    logic signed [smm_pkg::ELEMENT_BITS-1:0] b_reg;
    logic signed [smm_pkg::PROD_BITS-1:0]    prod_reg;
    logic signed [smm_pkg::SUM_BITS-1:0]     acc_reg;
    logic signed [smm_pkg::SUM_BITS-1:0]     acc_next;

    logic            v1_reg, v2_reg;
    smm_pkg::tag_t   tag1_reg, tag2_reg;
    smm_pkg::tag_t   tag_in;

    logic [smm_pkg::SUM_BITS-1:0] q_sum  [smm_pkg::OUT_DEPTH];
    logic [smm_pkg::ROW_BITS-1:0] q_row  [smm_pkg::OUT_DEPTH];
    logic [smm_pkg::COL_BITS-1:0] q_col  [smm_pkg::OUT_DEPTH];
    logic                         q_last [smm_pkg::OUT_DEPTH];

    logic [smm_pkg::OUT_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [smm_pkg::OUT_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [smm_pkg::OUT_CNT_BITS-1:0] cnt_reg,    cnt_next;
    logic                             push;
    logic                             pop;

    // Tag of the term being issued
    always_comb
    begin
        tag_in.first      = cmd.first;
        tag_in.last       = cmd.last;
        tag_in.row        = cmd.row;
        tag_in.col        = cmd.col;
        tag_in.final_elem = cmd.final_elem;
    end

    // Write loaded elements and read operand pairs
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && !cmd.wr_right)
        begin
            left_mem[cmd.wr_addr] <= s_tdata[smm_pkg::ELEMENT_BITS-1:0];
        end
        if (cmd.wr_en && cmd.wr_right)
        begin
            right_mem[cmd.wr_addr] <= s_tdata[smm_pkg::ELEMENT_BITS-1:0];
        end
        if (cmd.rd_en)
        begin
            a_reg <= left_mem[cmd.rd_left_addr];
            b_reg <= right_mem[cmd.rd_right_addr];
        end
    end

    // Multiply, then accumulate terms of one product element
    always_comb
    begin
        if (tag2_reg.first)
        begin
            acc_next = smm_pkg::SUM_BITS'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + smm_pkg::SUM_BITS'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg <= tag_in;
        tag2_reg <= tag1_reg;
        if (v1_reg)
        begin
            prod_reg <= a_reg * b_reg;
        end
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Advance pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
        end
    end

    // Result queue
    assign push = v2_reg && tag2_reg.last;
    assign pop  = (cnt_reg != '0) && m_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_sum[wr_ptr_reg]  <= acc_next;
            q_row[wr_ptr_reg]  <= tag2_reg.row;
            q_col[wr_ptr_reg]  <= tag2_reg.col;
            q_last[wr_ptr_reg] <= tag2_reg.final_elem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Present the queue head
    assign m_tvalid     = (cnt_reg != '0);
    assign m_tdata      = {{smm_pkg::M_PAD_BITS{1'b0}}, q_col[rd_ptr_reg],
                           q_row[rd_ptr_reg], q_sum[rd_ptr_reg]};
    assign m_tlast      = q_last[rd_ptr_reg];
    assign stat.out_pop = pop;

endmodule

FILE: sv/small_matrix_multiply.sv
// Top level of the small square matrix multiplier.
//
// Usage: write cfg_wdata with cfg_we high to set the size n (2, 3 or 4; values
// below 2 act as 2, above 4 as 4); this also drops any partial load. Then send
// n*n left elements in row-major order followed by n*n right elements on the
// s_ stream, one transaction each, signed Q8.8. s_tready stays high throughout
// loading. After the last right element the n*n product elements leave on the
// m_ stream in row-major order as exact signed Q18.16 sums, with row and
// column, and m_tlast marks the final one.
// One shared multiply-accumulate unit takes one term per cycle while the result
// queue has room for another product element, and each result sums n terms.
// The next load may start as soon as the last term has been read from the
// stores, while results still drain from a four-entry result queue.
// When the receiver stalls the queue fills and term issue pauses; nothing is
// lost. Reset sets n to 4, empties the queue and clears the load position;
// the element stores are not cleared and need no clearing pass.
module small_matrix_multiply (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [smm_pkg::CFG_BITS-1:0]    cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [smm_pkg::S_DATA_BITS-1:0] s_tdata,   // [15:0] element_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [smm_pkg::M_DATA_BITS-1:0] m_tdata,   // [33:0] product_value,
                                                       // [35:34] out_row,
                                                       // [37:36] out_col
    output logic                            m_tlast    // last_flag
);

    smm_pkg::cmd_t  cmd;
    smm_pkg::stat_t stat;

    smm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    smm_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
